@@ hw/rtl/pse_pkg.sv @@
// Shared package for the postfix stack evaluator.
// Holds widths, token kind and error codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int KIND_W          = 3;
    localparam int ERR_W           = 2;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int DIV_STEPS       = DATA_W;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV    = 3'd4;

    // Error and status codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZERO = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic             ld_tok;
        logic             push;
        logic             err_we;
        logic [ERR_W-1:0] err_code;
        logic             rd_req;
        logic             alu_wr;
        logic             div_start;
        logic             div_wr;
        logic             emit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              err_set;
        logic              sp_full;
        logic              sp_lt2;
        logic              top_zero;
        logic              div_done;
        logic              out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/pse_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg.
`default_nettype none

module pse_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pse_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [pse_pkg::DATA_W-1:0] i_divisor,
    output logic      [pse_pkg::DATA_W-1:0] o_quotient,
    output logic                            o_done
);

    localparam int CNT_W = $clog2(pse_pkg::DIV_STEPS + 1);
    localparam int W     = pse_pkg::DATA_W;

    logic [W-1:0]     r_quo;
    logic [W:0]       r_rem;
    logic [W-1:0]     r_div;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;

    logic [W-1:0]     w_abs_n;
    logic [W-1:0]     w_abs_d;
    logic [W:0]       w_shift;
    logic [W+1:0]     w_diff;

    // Take magnitudes; the most negative value maps to its unsigned magnitude
    assign w_abs_n = i_dividend[W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_abs_d = i_divisor[W-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // Restoring step: shift in next dividend bit, try subtracting the divisor
    assign w_shift = {r_rem[W-1:0], r_quo[W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};

    // Control: step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(pse_pkg::DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_abs_n;
            r_rem <= '0;
            r_div <= w_abs_d;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_cnt != '0) begin
            if (!w_diff[W+1]) begin
                r_rem <= w_diff[W:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    // Restore the sign; minus one into the most negative value wraps
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_done     = (r_cnt == '0);

endmodule

`default_nettype wire

@@ hw/rtl/pse_ctrl.sv @@
// Controller state machine for the postfix stack evaluator.
// Sequences token decode, stack read, arithmetic, division and result request.
// Depends on pse_pkg.
`default_nettype none

module pse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tok_valid,
    output logic               o_tok_ready,
    input  wire pse_pkg::t_sts i_sts,
    output pse_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (r_ready && i_tok_valid) begin
                    o_cmd.ld_tok = 1'b1;
                    n_state      = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_FINISH;
                if (!i_sts.err_set) begin
                    if (i_sts.kind == pse_pkg::KIND_NUMBER) begin
                        if (i_sts.sp_full) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = pse_pkg::ERR_OVER;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_sts.kind inside
                                 {[pse_pkg::KIND_ADD:pse_pkg::KIND_DIV]}) begin
                        if (i_sts.sp_lt2) begin
                            o_cmd.err_we   = 1'b1;
                            o_cmd.err_code = pse_pkg::ERR_UNDER;
                        end else begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_FINISH;
                if (i_sts.kind == pse_pkg::KIND_DIV) begin
                    if (i_sts.top_zero) begin
                        o_cmd.err_we   = 1'b1;
                        o_cmd.err_code = pse_pkg::ERR_DIVZERO;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end else begin
                    o_cmd.alu_wr = 1'b1;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // For a last token, hold until the output register can take the result request
                if (!i_sts.last) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_tok_ready = r_ready;

endmodule

`default_nettype wire

@@ hw/rtl/pse_dp.sv @@
// Datapath for the postfix stack evaluator: token register, stack memory,
// top-of-stack register, add/sub/mul unit, divider and output register.
// Depends on pse_pkg and pse_div.
`default_nettype none

module pse_dp #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pse_pkg::t_cmd              i_cmd,
    output pse_pkg::t_sts                   o_sts,
    input  wire logic [pse_pkg::KIND_W-1:0] i_kind,
    input  wire logic [pse_pkg::DATA_W-1:0] i_value,
    input  wire logic                       i_last,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [pse_pkg::DATA_W-1:0] o_answer,
    output logic      [pse_pkg::ERR_W-1:0]  o_status
);

    localparam int W     = pse_pkg::DATA_W;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Stack memory holds every entry below the top
    logic [W-1:0] r_mem [STACK_DEPTH];

    logic [pse_pkg::KIND_W-1:0] r_kind;
    logic [W-1:0]               r_value;
    logic                       r_last;
    logic [SP_W-1:0]            r_sp;
    logic [pse_pkg::ERR_W-1:0]  r_err;
    logic [W-1:0]               r_top;
    logic [W-1:0]               r_rd;
    logic                       r_out_valid;
    logic [W-1:0]               r_answer;
    logic [pse_pkg::ERR_W-1:0]  r_status;

    logic [SP_W-1:0]  w_sp_m1;
    logic [SP_W-1:0]  w_sp_m2;
    logic [2*W-1:0]   w_prod;
    logic [W-1:0]     w_alu;
    logic [W-1:0]     w_quo;
    logic             w_div_done;

    assign w_sp_m1 = r_sp - 1'b1;
    assign w_sp_m2 = r_sp - SP_W'(2);
    assign w_prod  = r_rd * r_top;

    // Second-from-top op top
    always_comb begin
        case (r_kind)
            pse_pkg::KIND_ADD: w_alu = r_rd + r_top;
            pse_pkg::KIND_SUB: w_alu = r_rd - r_top;
            pse_pkg::KIND_MUL: w_alu = w_prod[W-1:0];
            default:           w_alu = r_top;
        endcase
    end

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // Latch the token on request
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_tok) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_last  <= i_last;
        end
    end

    // Stack memory: spill the old top on push, read second entry on request
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_sp != '0)) begin
            r_mem[w_sp_m1[IDX_W-1:0]] <= r_top;
        end
        if (i_cmd.rd_req) begin
            r_rd <= r_mem[w_sp_m2[IDX_W-1:0]];
        end
    end

    // Top of stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= r_value;
        end else if (i_cmd.alu_wr) begin
            r_top <= w_alu;
        end else if (i_cmd.div_wr) begin
            r_top <= w_quo;
        end
    end

    // Stack pointer and sticky error; clear both when the result goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_err <= pse_pkg::ERR_NONE;
        end else if (i_cmd.emit) begin
            r_sp  <= '0;
            r_err <= pse_pkg::ERR_NONE;
        end else begin
            if (i_cmd.push) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.alu_wr || i_cmd.div_wr) begin
                r_sp <= w_sp_m1;
            end
            if (i_cmd.err_we) begin
                r_err <= i_cmd.err_code;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_err != pse_pkg::ERR_NONE) begin
                r_answer <= '0;
                r_status <= r_err;
            end else if (r_sp == '0) begin
                r_answer <= '0;
                r_status <= pse_pkg::ERR_UNDER;
            end else begin
                r_answer <= r_top;
                r_status <= pse_pkg::ERR_NONE;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.kind     = r_kind;
        o_sts.last     = r_last;
        o_sts.err_set  = (r_err != pse_pkg::ERR_NONE);
        o_sts.sp_full  = (r_sp == SP_W'(STACK_DEPTH));
        o_sts.sp_lt2   = (r_sp < SP_W'(2));
        o_sts.top_zero = (r_top == '0);
        o_sts.div_done = w_div_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

endmodule

`default_nettype wire

@@ hw/rtl/postfix_stack_evaluator_unit.sv @@
// Postfix stack evaluator: one token per request, result on the last token.
// Tokens do not overlap: ready returns only after a token has been through decode, a
// stack read for add/sub/mul/div and the 32-step divider for a divide. A number, an
// unused kind or a token that is ignored or fails in decode skips the read; a divide by
// zero skips the divider. A last token's result also waits while the output is stalled.
// Reset (synchronous, active low) empties the stack and clears the error; memory is kept.
`default_nettype none

module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic signed [pse_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] operand_value
    input  wire logic        [pse_pkg::KIND_W-1:0] s_axis_tuser,  // [2:0] req_type
    input  wire logic                              s_axis_tlast,  // last_token
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic signed      [pse_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] answer
    output logic             [pse_pkg::ERR_W-1:0]  m_axis_tuser   // [1:0] status
);

    pse_pkg::t_cmd w_cmd;
    pse_pkg::t_sts w_sts;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (s_axis_tvalid),
        .o_tok_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_answer    (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ hw/rtl/pse_checker.sv @@
// Port-level checks for the postfix stack evaluator, bound to the top level.
// Depends on pse_pkg.
`default_nettype none

module pse_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [pse_pkg::DATA_W-1:0] m_axis_tdata,
    input wire logic [pse_pkg::ERR_W-1:0]  m_axis_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // A failed expression reports a zero answer
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != pse_pkg::ERR_NONE)) |->
        (m_axis_tdata == '0))
        else $error("nonzero answer with error status");

    // One token in flight: ready drops right after a request
    a_one_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after token request");

    // A result appears only as a token retires
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(!s_axis_tready) && s_axis_tready))
        else $error("result without a retiring token");

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
